>>> rtl/hsv2rgb_pkg.sv
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    localparam int unsigned HUE_W   = 9;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned WGT_W   = 6;
    localparam int unsigned REM_W   = 7;
    localparam int unsigned TERM_W  = 14;
    localparam int unsigned NUM_W   = 22;
    localparam int unsigned RECIP_W = 23;
    localparam int unsigned SHIFT   = 36;
    localparam int unsigned PROD_W  = NUM_W + RECIP_W;
    localparam int unsigned QUOT_W  = PROD_W - SHIFT;

    localparam logic [HUE_W-1:0]   HUE_FULL  = 9'd360;
    localparam logic [HUE_W-1:0]   HUE_SIXTY = 9'd60;
    localparam logic [HUE_W-1:0]   HUE_THIRD = 9'd120;
    localparam logic [TERM_W-1:0]  WGT_FULL  = 14'd60;
    localparam logic [CHAN_W-1:0]  CHAN_MAX  = 8'd255;
    localparam logic [NUM_W-1:0]   ROUND_ADD = 22'd7650;
    // Ceiling of 2^36 / 15300; exact for every numerator below 2^22.
    localparam logic [RECIP_W-1:0] RECIP     = 23'd4491470;

    typedef enum logic [2:0] {
        SEC_RED_YEL  = 3'd0,
        SEC_YEL_GRN  = 3'd1,
        SEC_GRN_CYN  = 3'd2,
        SEC_CYN_BLU  = 3'd3,
        SEC_BLU_MAG  = 3'd4,
        SEC_MAG_RED  = 3'd5
    } t_sector;

    function automatic t_sector hue_sector(input logic [HUE_W-1:0] hue);
        t_sector sec;
        priority if (hue < HUE_SIXTY) begin
            sec = SEC_RED_YEL;
        end else if (hue < 9'd120) begin
            sec = SEC_YEL_GRN;
        end else if (hue < 9'd180) begin
            sec = SEC_GRN_CYN;
        end else if (hue < 9'd240) begin
            sec = SEC_CYN_BLU;
        end else if (hue < 9'd300) begin
            sec = SEC_BLU_MAG;
        end else begin
            sec = SEC_MAG_RED;
        end
        return sec;
    endfunction

endpackage

>>> rtl/hsv_to_rgb_converter_unit.sv
`timescale 1ns / 1ps
// HSV to RGB converter, one pixel per request.
// The strobe marks the result when the request leaves the last register stage.
// Throughput: one request per cycle; busy stays low, as the result side never stalls.
// The latency comes from the five register stages that split the weight, numerator and
// reciprocal multiplications.
// Reset clears the stage valid bits only; the pipeline is empty after reset.
module hsv_to_rgb_converter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]  i_hue_deg,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0] i_saturation,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0] i_brightness,
    output logic                           o_strobe,
    output logic [hsv2rgb_pkg::CHAN_W-1:0] o_red,
    output logic [hsv2rgb_pkg::CHAN_W-1:0] o_green,
    output logic [hsv2rgb_pkg::CHAN_W-1:0] o_blue
);

    localparam int unsigned HW = hsv2rgb_pkg::HUE_W;
    localparam int unsigned CW = hsv2rgb_pkg::CHAN_W;
    localparam int unsigned WW = hsv2rgb_pkg::WGT_W;
    localparam int unsigned RW = hsv2rgb_pkg::REM_W;
    localparam int unsigned TW = hsv2rgb_pkg::TERM_W;
    localparam int unsigned NW = hsv2rgb_pkg::NUM_W;
    localparam int unsigned PW = hsv2rgb_pkg::PROD_W;
    localparam int unsigned QW = hsv2rgb_pkg::QUOT_W;

    logic [HW-1:0]        n_hue;
    hsv2rgb_pkg::t_sector n_sector;
    logic [RW-1:0]        n_rem;
    logic [WW-1:0]        n_wgt;

    logic                 r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;
    hsv2rgb_pkg::t_sector r_sec1, r_sec2, r_sec3, r_sec4;
    logic [CW-1:0]        r_val1, r_val2, r_val3, r_val4;
    logic [CW-1:0]        r_sat1;
    logic [WW-1:0]        r_wgt1;
    logic [TW-1:0]        r_sec_term2, r_base_term2;
    logic [NW-1:0]        r_sec_num3, r_base_num3;
    logic [QW-1:0]        r_sec_q4, r_base_q4;
    logic [CW-1:0]        r_red, r_green, r_blue;

    logic [TW-1:0]        n_base_term;
    logic [TW-1:0]        n_sec_term;
    logic [NW-1:0]        n_sec_num, n_base_num;
    logic [PW-1:0]        n_sec_prod, n_base_prod;
    logic [CW-1:0]        n_full, n_sec, n_base;
    logic [CW-1:0]        n_red, n_green, n_blue;

    assign busy = 1'b0;

    always_comb begin
        n_hue = (i_hue_deg >= hsv2rgb_pkg::HUE_FULL) ? i_hue_deg - hsv2rgb_pkg::HUE_FULL
                                                     : i_hue_deg;
        n_sector = hsv2rgb_pkg::hue_sector(n_hue);
        unique case (n_sector)
            hsv2rgb_pkg::SEC_RED_YEL,
            hsv2rgb_pkg::SEC_YEL_GRN: n_rem = RW'(n_hue);
            hsv2rgb_pkg::SEC_GRN_CYN,
            hsv2rgb_pkg::SEC_CYN_BLU: n_rem = RW'(n_hue - hsv2rgb_pkg::HUE_THIRD);
            default:                  n_rem = RW'(n_hue - (hsv2rgb_pkg::HUE_THIRD << 1));
        endcase
        if (HW'(n_rem) >= hsv2rgb_pkg::HUE_SIXTY) begin
            n_wgt = WW'(hsv2rgb_pkg::HUE_THIRD - HW'(n_rem));
        end else begin
            n_wgt = WW'(n_rem);
        end
    end

    always_comb begin
        n_base_term = TW'(hsv2rgb_pkg::WGT_FULL * TW'(hsv2rgb_pkg::CHAN_MAX - r_sat1));
        n_sec_term  = TW'(TW'(r_sat1) * TW'(r_wgt1)) + n_base_term;
        n_sec_num   = NW'(NW'(r_val2) * NW'(r_sec_term2)) + hsv2rgb_pkg::ROUND_ADD;
        n_base_num  = NW'(NW'(r_val2) * NW'(r_base_term2)) + hsv2rgb_pkg::ROUND_ADD;
        n_sec_prod  = PW'(r_sec_num3) * PW'(hsv2rgb_pkg::RECIP);
        n_base_prod = PW'(r_base_num3) * PW'(hsv2rgb_pkg::RECIP);
    end

    always_comb begin
        n_full = r_val4;
        n_sec  = (r_sec_q4 > QW'(hsv2rgb_pkg::CHAN_MAX)) ? hsv2rgb_pkg::CHAN_MAX
                                                         : r_sec_q4[CW-1:0];
        n_base = (r_base_q4 > QW'(hsv2rgb_pkg::CHAN_MAX)) ? hsv2rgb_pkg::CHAN_MAX
                                                          : r_base_q4[CW-1:0];
        unique case (r_sec4)
            hsv2rgb_pkg::SEC_RED_YEL: begin
                n_red = n_full; n_green = n_sec;  n_blue = n_base;
            end
            hsv2rgb_pkg::SEC_YEL_GRN: begin
                n_red = n_sec;  n_green = n_full; n_blue = n_base;
            end
            hsv2rgb_pkg::SEC_GRN_CYN: begin
                n_red = n_base; n_green = n_full; n_blue = n_sec;
            end
            hsv2rgb_pkg::SEC_CYN_BLU: begin
                n_red = n_base; n_green = n_sec;  n_blue = n_full;
            end
            hsv2rgb_pkg::SEC_BLU_MAG: begin
                n_red = n_sec;  n_green = n_base; n_blue = n_full;
            end
            default: begin
                n_red = n_full; n_green = n_base; n_blue = n_sec;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            r_vld1 <= start & ~busy;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sec1       <= n_sector;
        r_wgt1       <= n_wgt;
        r_sat1       <= i_saturation;
        r_val1       <= i_brightness;

        r_sec2       <= r_sec1;
        r_val2       <= r_val1;
        r_sec_term2  <= n_sec_term;
        r_base_term2 <= n_base_term;

        r_sec3       <= r_sec2;
        r_val3       <= r_val2;
        r_sec_num3   <= n_sec_num;
        r_base_num3  <= n_base_num;

        r_sec4       <= r_sec3;
        r_val4       <= r_val3;
        r_sec_q4     <= n_sec_prod[PW-1:hsv2rgb_pkg::SHIFT];
        r_base_q4    <= n_base_prod[PW-1:hsv2rgb_pkg::SHIFT];

        r_red        <= n_red;
        r_green      <= n_green;
        r_blue       <= n_blue;
    end

    assign o_strobe = r_vld5;
    assign o_red    = r_red;
    assign o_green  = r_green;
    assign o_blue   = r_blue;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned HUE_W           = hsv2rgb_pkg::HUE_W;
    localparam int unsigned CHAN_W          = hsv2rgb_pkg::CHAN_W;
    localparam int unsigned RANDOM_REQUESTS = 1200;
    localparam int unsigned DIRECTED_ROWS   = 24;
    localparam int unsigned IDLE_PERCENT    = 18;
    localparam int unsigned DRAIN_CYCLES    = 10;
    localparam int unsigned REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] val;
        logic              known;
        t_rgb              rgb;
    } t_pixel_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [HUE_W-1:0]  i_hue_deg;
    logic [CHAN_W-1:0] i_saturation;
    logic [CHAN_W-1:0] i_brightness;
    logic              o_strobe;
    logic [CHAN_W-1:0] o_red;
    logic [CHAN_W-1:0] o_green;
    logic [CHAN_W-1:0] o_blue;

    t_rgb        pending_rgb[$];
    int unsigned mismatch_count;

    // Primaries, secondaries, wrapped hues, greys and black are known by eye.
    t_pixel_row directed_rows [0:DIRECTED_ROWS-1] = '{
        '{9'd0,   8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
        '{9'd60,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
        '{9'd120, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},
        '{9'd180, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},
        '{9'd240, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{9'd300, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd255}},
        '{9'd360, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
        '{9'd420, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
        '{9'd480, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},
        '{9'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
        '{9'd200, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{9'd100, 8'd0,   8'd77,  1'b1, '{8'd77,  8'd77,  8'd77}},
        '{9'd300, 8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
        '{9'd511, 8'd255, 8'd255, 1'b0, '0},
        '{9'd359, 8'd255, 8'd255, 1'b0, '0},
        '{9'd59,  8'd255, 8'd255, 1'b0, '0},
        '{9'd61,  8'd128, 8'd200, 1'b0, '0},
        '{9'd30,  8'd255, 8'd255, 1'b0, '0},
        '{9'd90,  8'd1,   8'd254, 1'b0, '0},
        '{9'd150, 8'd254, 8'd1,   1'b0, '0},
        '{9'd210, 8'd128, 8'd128, 1'b0, '0},
        '{9'd270, 8'd200, 8'd100, 1'b0, '0},
        '{9'd330, 8'd17,  8'd240, 1'b0, '0},
        '{9'd256, 8'd170, 8'd85,  1'b0, '0}
    };

    hsv_to_rgb_converter_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_hue_deg    (i_hue_deg),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_strobe     (o_strobe),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    function automatic logic [CHAN_W-1:0] scaled_channel(input int unsigned val,
                                                         input int unsigned sat,
                                                         input int unsigned weight);
        int unsigned num;
        int unsigned quot;
        num  = val * (sat * weight + 60 * (255 - sat));
        quot = (2 * num + 15300) / 30600;
        if (quot > 255) begin
            quot = 255;
        end
        return quot[CHAN_W-1:0];
    endfunction

    function automatic t_rgb hsv_to_rgb(input logic [HUE_W-1:0] hue_in,
                                        input logic [CHAN_W-1:0] sat,
                                        input logic [CHAN_W-1:0] val);
        int unsigned          hue;
        int unsigned          rem;
        int unsigned          gap;
        int unsigned          weight;
        hsv2rgb_pkg::t_sector sector;
        logic [CHAN_W-1:0]    full;
        logic [CHAN_W-1:0]    second;
        logic [CHAN_W-1:0]    base;
        t_rgb                 rgb;
        hue = hue_in;
        if (hue >= 360) begin
            hue = hue - 360;
        end
        rem    = hue % 120;
        gap    = (rem >= 60) ? rem - 60 : 60 - rem;
        weight = 60 - gap;
        sector = hsv2rgb_pkg::t_sector'(hue / 60);
        full   = scaled_channel(val, sat, 60);
        second = scaled_channel(val, sat, weight);
        base   = scaled_channel(val, sat, 0);
        case (sector)
            hsv2rgb_pkg::SEC_RED_YEL: rgb = '{full, second, base};
            hsv2rgb_pkg::SEC_YEL_GRN: rgb = '{second, full, base};
            hsv2rgb_pkg::SEC_GRN_CYN: rgb = '{base, full, second};
            hsv2rgb_pkg::SEC_CYN_BLU: rgb = '{base, second, full};
            hsv2rgb_pkg::SEC_BLU_MAG: rgb = '{second, base, full};
            default:                  rgb = '{full, base, second};
        endcase
        return rgb;
    endfunction

    task automatic issue_request(input logic [HUE_W-1:0] hue, input logic [CHAN_W-1:0] sat,
                                 input logic [CHAN_W-1:0] val, input bit may_idle,
                                 input bit known, input t_rgb known_rgb);
        while (may_idle && $urandom_range(99) < IDLE_PERCENT) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_hue_deg    <= hue;
        i_saturation <= sat;
        i_brightness <= val;
        do begin
            @(posedge i_clk);
        end while (busy);
        pending_rgb.push_back(known ? known_rgb : hsv_to_rgb(hue, sat, val));
    endtask

    function automatic logic [CHAN_W-1:0] random_level();
        int unsigned pick;
        pick = $urandom_range(19);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return hsv2rgb_pkg::CHAN_MAX;
        end
        return CHAN_W'($urandom_range(255));
    endfunction

    function automatic logic [HUE_W-1:0] random_hue();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            return HUE_W'($urandom_range(511, 361));
        end else if (pick == 1) begin
            return HUE_W'(60 * $urandom_range(6) + $urandom_range(1));
        end else if (pick == 2) begin
            return HUE_W'(60 * $urandom_range(6, 1) - 1);
        end
        return HUE_W'($urandom_range(360));
    endfunction

    initial begin
        i_clk = 1'b0;
        forever begin
            #6 i_clk = ~i_clk;
        end
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        t_rgb expected;
        if (i_rst_n && o_strobe) begin
            if (pending_rgb.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("Unexpected result: rgb %0d %0d %0d", o_red, o_green, o_blue);
                end
            end else begin
                expected = pending_rgb.pop_front();
                if (o_red !== expected.red || o_green !== expected.green
                        || o_blue !== expected.blue) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("Mismatch: expected rgb %0d %0d %0d, got %0d %0d %0d",
                                 expected.red, expected.green, expected.blue,
                                 o_red, o_green, o_blue);
                    end
                end
            end
        end
    end

    initial begin
        bit may_idle;
        mismatch_count = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_hue_deg      = '0;
        i_saturation   = '0;
        i_brightness   = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[idx]) begin
            issue_request(directed_rows[idx].hue, directed_rows[idx].sat,
                          directed_rows[idx].val, 1'b1, directed_rows[idx].known,
                          directed_rows[idx].rgb);
        end

        // A block of back-to-back requests sits in the middle of the random part.
        for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
            may_idle = !(n >= 500 && n < 800);
            issue_request(random_hue(), random_level(), random_level(), may_idle, 1'b0, '0);
        end
        start <= 1'b0;

        while (pending_rgb.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_rgb.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
